/* hdl/dmsp_pkg.sv */
// Shared types and constants for the dual motor speed PI loop.
// Depends on nothing; every other file in hdl imports it.
package dmsp_pkg;

    localparam int TARGET_W   = 16;
    localparam int BASE_W     = 13;
    localparam int DUTY_W     = 13;
    localparam int GAIN_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int SCALE_W    = 24;
    localparam int LIMIT_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FILT_W     = 32;
    localparam int SPEED_W    = 16;
    localparam int ERR_W      = 18;
    localparam int DIFF_W     = 19;
    localparam int PWM_W      = 13;
    localparam int MIX_W      = 14;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int Q16_SHIFT  = 16;

    localparam logic [WEIGHT_W-1:0]        WEIGHT_ONE = 17'h10000;
    localparam logic signed [TARGET_W-1:0] DEADBAND   = 16'sd5;

    localparam logic [GAIN_W-1:0]   RST_GAIN_DIFF_A    = 16'd7885;
    localparam logic [GAIN_W-1:0]   RST_GAIN_ERR_A     = 16'd0;
    localparam logic [GAIN_W-1:0]   RST_GAIN_DIFF_B    = 16'd7680;
    localparam logic [GAIN_W-1:0]   RST_GAIN_ERR_B     = 16'd0;
    localparam logic [WEIGHT_W-1:0] RST_SMOOTHING      = 17'd32768;
    localparam logic [SCALE_W-1:0]  RST_COUNT_TO_SPEED = 24'd65536;
    localparam logic [LIMIT_W-1:0]  RST_DRIVE_LIMIT    = 12'd1220;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIFF_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ERR_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIFF_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ERR_B     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_TO_SPEED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_RAW,
        S_MUL_OLD,
        S_MUL_NEW,
        S_FILT,
        S_ERR,
        S_MUL_ERR,
        S_MUL_DIFF,
        S_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_raw;
        logic mul_old;
        logic mul_new;
        logic filt;
        logic err;
        logic mul_err;
        logic mul_diff;
        logic acc;
        logic out_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

/* hdl/dmsp_if.sv */
// Valid/ready channels for input items and result items.
// Depends on dmsp_pkg for the field widths.
interface dmsp_item_if
    import dmsp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
);
    logic                       valid;
    logic                       ready;
    logic signed [COUNT_WIDTH-1:0] enc_count_a;
    logic signed [COUNT_WIDTH-1:0] enc_count_b;
    logic signed [TARGET_W-1:0] target_speed;
    logic signed [BASE_W-1:0]   base_duty;
    logic                       turn_mode;

    modport source (
        output valid, enc_count_a, enc_count_b, target_speed, base_duty, turn_mode,
        input  ready
    );
    modport sink (
        input  valid, enc_count_a, enc_count_b, target_speed, base_duty, turn_mode,
        output ready
    );
endinterface

interface dmsp_result_if
    import dmsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_duty;
    logic              left_forward;
    logic [DUTY_W-1:0] right_duty;
    logic              right_forward;

    modport source (
        output valid, left_duty, left_forward, right_duty, right_forward,
        input  ready
    );
    modport sink (
        input  valid, left_duty, left_forward, right_duty, right_forward,
        output ready
    );
endinterface

/* hdl/dual_motor_speed_pi_loop.sv */
// Top level of the dual motor speed PI loop: configuration registers and wiring
// of sequencer, wheel datapaths and mixer. Depends on dmsp_pkg and dmsp_if.
//
// One item is one control tick: two encoder counts, a target speed, a base
// duty and a mode; one result item with duty and direction per motor comes
// back for each. An accepted item runs through the sequencer steps before its
// result is loaded into the output register, and the block takes no new item
// until the sequencer is back in idle: eight sequencer steps share one
// multiplier per wheel (count scaling, two filter products, two PI products),
// then a mixing step. A result left waiting holds the sequencer in its last
// step; a new item is still taken while an earlier result waits. Write
// configuration only while no item is in work; a write takes effect at once.
module dual_motor_speed_pi_loop
    import dmsp_pkg::*;
#(
    parameter int COUNT_WIDTH    = 32,
    parameter int GAIN_FRAC_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dmsp_item_if.sink             i_item,
    dmsp_result_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [GAIN_W-1:0]   r_gain_diff_a;
    logic [GAIN_W-1:0]   r_gain_err_a;
    logic [GAIN_W-1:0]   r_gain_diff_b;
    logic [GAIN_W-1:0]   r_gain_err_b;
    logic [WEIGHT_W-1:0] r_smoothing;
    logic [SCALE_W-1:0]  r_count_to_speed;
    logic [LIMIT_W-1:0]  r_drive_limit;

    t_dp_cmd                    cmd;
    t_dp_stat                   stat;
    logic                       in_ready;
    logic signed [TARGET_W-1:0] target;
    logic signed [PWM_W-1:0]    pwm_a;
    logic signed [PWM_W-1:0]    pwm_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_diff_a    <= RST_GAIN_DIFF_A;
            r_gain_err_a     <= RST_GAIN_ERR_A;
            r_gain_diff_b    <= RST_GAIN_DIFF_B;
            r_gain_err_b     <= RST_GAIN_ERR_B;
            r_smoothing      <= RST_SMOOTHING;
            r_count_to_speed <= RST_COUNT_TO_SPEED;
            r_drive_limit    <= RST_DRIVE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_DIFF_A:    r_gain_diff_a    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_ERR_A:     r_gain_err_a     <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_DIFF_B:    r_gain_diff_b    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_ERR_B:     r_gain_err_b     <= i_cfg_data[GAIN_W-1:0];
                REG_SMOOTHING:      r_smoothing      <= i_cfg_data[WEIGHT_W-1:0];
                REG_COUNT_TO_SPEED: r_count_to_speed <= i_cfg_data[SCALE_W-1:0];
                REG_DRIVE_LIMIT:    r_drive_limit    <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_item.ready = in_ready;

    dmsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    dmsp_wheel #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_wheel_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_count     (i_item.enc_count_a),
        .i_target    (target),
        .i_gain_diff (r_gain_diff_a),
        .i_gain_err  (r_gain_err_a),
        .i_weight    (r_smoothing),
        .i_scale     (r_count_to_speed),
        .i_limit     (r_drive_limit),
        .o_pwm       (pwm_a)
    );

    dmsp_wheel #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_wheel_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_count     (i_item.enc_count_b),
        .i_target    (target),
        .i_gain_diff (r_gain_diff_b),
        .i_gain_err  (r_gain_err_b),
        .i_weight    (r_smoothing),
        .i_scale     (r_count_to_speed),
        .i_limit     (r_drive_limit),
        .o_pwm       (pwm_b)
    );

    dmsp_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_target (i_item.target_speed),
        .i_base   (i_item.base_duty),
        .i_turn   (i_item.turn_mode),
        .i_pwm_a  (pwm_a),
        .i_pwm_b  (pwm_b),
        .o_target (target),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

/* hdl/dmsp_ctrl.sv */
// Sequencer for one control tick: steps both wheel datapaths and the mixer.
// Depends on dmsp_pkg for the state type and command/status structs.
module dmsp_ctrl
    import dmsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL_RAW;
                end
            end
            S_MUL_RAW:  n_state = S_MUL_OLD;
            S_MUL_OLD:  n_state = S_MUL_NEW;
            S_MUL_NEW:  n_state = S_FILT;
            S_FILT:     n_state = S_ERR;
            S_ERR:      n_state = S_MUL_ERR;
            S_MUL_ERR:  n_state = S_MUL_DIFF;
            S_MUL_DIFF: n_state = S_ACC;
            S_ACC:      n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL_RAW:  o_cmd.mul_raw  = 1'b1;
            S_MUL_OLD:  o_cmd.mul_old  = 1'b1;
            S_MUL_NEW:  o_cmd.mul_new  = 1'b1;
            S_FILT:     o_cmd.filt     = 1'b1;
            S_ERR:      o_cmd.err      = 1'b1;
            S_MUL_ERR:  o_cmd.mul_err  = 1'b1;
            S_MUL_DIFF: o_cmd.mul_diff = 1'b1;
            S_ACC:      o_cmd.acc      = 1'b1;
            S_OUT:      o_cmd.out_wr   = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

/* hdl/dmsp_wheel.sv */
// Per-wheel datapath: count delta, speed scaling, low-pass filter and the
// incremental PI accumulator around one shared multiplier. Depends on dmsp_pkg.
module dmsp_wheel
    import dmsp_pkg::*;
#(
    parameter int COUNT_WIDTH    = 32,
    parameter int GAIN_FRAC_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    input  logic signed [COUNT_WIDTH-1:0] i_count,
    input  logic signed [TARGET_W-1:0]  i_target,
    input  logic [GAIN_W-1:0]           i_gain_diff,
    input  logic [GAIN_W-1:0]           i_gain_err,
    input  logic [WEIGHT_W-1:0]         i_weight,
    input  logic [SCALE_W-1:0]          i_scale,
    input  logic [LIMIT_W-1:0]          i_limit,
    output logic signed [PWM_W-1:0]     o_pwm
);

    localparam int ACC_W = LIMIT_W + GAIN_FRAC_BITS + 1;
    localparam int SAT_W = PROD_W - FILT_W + 1;

    logic [COUNT_WIDTH-1:0]        r_prev;
    logic signed [FILT_W-1:0]      r_filt;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ERR_W-1:0]       r_perr;

    logic signed [COUNT_WIDTH-1:0] r_delta;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [FILT_W-1:0]      r_raw;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [ERR_W-1:0]       r_err;
    logic signed [DIFF_W-1:0]      r_diff;

    logic [COUNT_WIDTH-1:0]        delta_bits;
    logic [WEIGHT_W-1:0]           w_eff;
    logic [WEIGHT_W-1:0]           w_rest;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      mul_p;
    logic [SAT_W-1:0]              prod_hi;
    logic signed [FILT_W-1:0]      raw_sat;
    logic signed [SUM_W-1:0]       sum_next;
    logic                          speed_up;
    logic signed [SPEED_W-1:0]     speed;
    logic signed [ERR_W-1:0]       err_next;
    logic signed [DIFF_W-1:0]      diff_next;
    logic signed [SUM_W-1:0]       lim_pos;
    logic signed [SUM_W-1:0]       lim_neg;
    logic signed [SUM_W-1:0]       acc_clamp;
    logic                          pwm_up;

    assign delta_bits = i_count - r_prev;
    assign w_eff      = (i_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_weight;
    assign w_rest     = WEIGHT_ONE - w_eff;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_raw) begin
            mul_a = MUL_A_W'(r_delta);
            mul_b = $signed({1'b0, i_scale});
        end else if (i_cmd.mul_old) begin
            mul_a = r_filt;
            mul_b = $signed({{(MUL_B_W-WEIGHT_W){1'b0}}, w_rest});
        end else if (i_cmd.mul_new) begin
            mul_a = r_raw;
            mul_b = $signed({{(MUL_B_W-WEIGHT_W){1'b0}}, w_eff});
        end else if (i_cmd.mul_err) begin
            mul_a = MUL_A_W'(r_err);
            mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, i_gain_err});
        end else if (i_cmd.mul_diff) begin
            mul_a = MUL_A_W'(r_diff);
            mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, i_gain_diff});
        end
    end

    assign mul_p = mul_a * mul_b;

    assign prod_hi = r_prod[PROD_W-1:FILT_W-1];
    always_comb begin
        if ((&prod_hi) || !(|prod_hi)) begin
            raw_sat = r_prod[FILT_W-1:0];
        end else if (r_prod[PROD_W-1]) begin
            raw_sat = $signed({1'b1, {(FILT_W-1){1'b0}}});
        end else begin
            raw_sat = $signed({1'b0, {(FILT_W-1){1'b1}}});
        end
    end

    assign sum_next = r_sum + SUM_W'(r_prod);

    assign speed_up  = r_filt[FILT_W-1] && (|r_filt[Q16_SHIFT-1:0]);
    assign speed     = $signed(r_filt[FILT_W-1:Q16_SHIFT])
                     + $signed({{(SPEED_W-1){1'b0}}, speed_up});
    assign err_next  = ERR_W'(i_target) - ERR_W'(speed);
    assign diff_next = DIFF_W'(r_err) - DIFF_W'(r_perr);

    assign lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, i_limit}) <<< GAIN_FRAC_BITS;
    assign lim_neg = -lim_pos;

    always_comb begin
        if (sum_next > lim_pos) begin
            acc_clamp = lim_pos;
        end else if (sum_next < lim_neg) begin
            acc_clamp = lim_neg;
        end else begin
            acc_clamp = sum_next;
        end
    end

    assign pwm_up = r_acc[ACC_W-1] && (|r_acc[GAIN_FRAC_BITS-1:0]);
    assign o_pwm  = $signed(r_acc[ACC_W-1:GAIN_FRAC_BITS])
                  + $signed({{(PWM_W-1){1'b0}}, pwm_up});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_filt <= '0;
            r_acc  <= '0;
            r_perr <= '0;
        end else begin
            if (i_cmd.load) begin
                r_prev <= i_count;
            end
            if (i_cmd.filt) begin
                r_filt <= sum_next[Q16_SHIFT+FILT_W-1:Q16_SHIFT];
            end
            if (i_cmd.acc) begin
                r_acc  <= acc_clamp[ACC_W-1:0];
                r_perr <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delta <= $signed(delta_bits);
        end
        if (i_cmd.mul_raw || i_cmd.mul_old || i_cmd.mul_new
                || i_cmd.mul_err || i_cmd.mul_diff) begin
            r_prod <= mul_p;
        end
        if (i_cmd.mul_old) begin
            r_raw <= raw_sat;
        end
        if (i_cmd.mul_new) begin
            r_sum <= SUM_W'(r_prod);
        end
        if (i_cmd.mul_diff) begin
            r_sum <= SUM_W'(r_acc) + SUM_W'(r_prod);
        end
        if (i_cmd.err) begin
            r_err <= err_next;
        end
        if (i_cmd.mul_err) begin
            r_diff <= diff_next;
        end
    end

endmodule

/* hdl/dmsp_mix.sv */
// Tick command latch with deadband, and the motor mixer with its result register.
// Depends on dmsp_pkg and the result channel in dmsp_if.
module dmsp_mix
    import dmsp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic signed [TARGET_W-1:0] i_target,
    input  logic signed [BASE_W-1:0]   i_base,
    input  logic                       i_turn,
    input  logic signed [PWM_W-1:0]    i_pwm_a,
    input  logic signed [PWM_W-1:0]    i_pwm_b,
    output logic signed [TARGET_W-1:0] o_target,
    output t_dp_stat                   o_stat,
    dmsp_result_if.source              o_result
);

    logic signed [TARGET_W-1:0] r_target;
    logic signed [BASE_W-1:0]   r_base;
    logic                       r_turn;
    logic                       r_valid;
    logic [DUTY_W-1:0]          r_left_duty;
    logic                       r_left_forward;
    logic [DUTY_W-1:0]          r_right_duty;
    logic                       r_right_forward;

    logic                       in_deadband;
    logic signed [MIX_W-1:0]    left_mix;
    logic signed [MIX_W-1:0]    right_mix;
    logic signed [MIX_W-1:0]    left_abs;
    logic signed [MIX_W-1:0]    right_abs;
    logic signed [MIX_W-1:0]    pwm_b_abs;
    logic signed [MIX_W-1:0]    turn_sum;
    logic [DUTY_W-1:0]          left_duty;
    logic                       left_forward;
    logic [DUTY_W-1:0]          right_duty;
    logic                       right_forward;

    assign in_deadband = !i_turn && (i_target > -DEADBAND) && (i_target < DEADBAND);

    assign left_mix  = MIX_W'(r_base) - MIX_W'(i_pwm_a);
    assign right_mix = MIX_W'(r_base) + MIX_W'(i_pwm_b);
    assign left_abs  = left_mix[MIX_W-1] ? -left_mix : left_mix;
    assign right_abs = right_mix[MIX_W-1] ? -right_mix : right_mix;
    assign pwm_b_abs = i_pwm_b[PWM_W-1] ? -MIX_W'(i_pwm_b) : MIX_W'(i_pwm_b);
    assign turn_sum  = MIX_W'(r_base) + pwm_b_abs;

    always_comb begin
        if (r_turn) begin
            left_duty     = '0;
            left_forward  = (i_pwm_a > 0);
            right_duty    = turn_sum[MIX_W-1] ? '0 : turn_sum[DUTY_W-1:0];
            right_forward = (i_pwm_b > 0);
        end else begin
            left_duty     = left_abs[DUTY_W-1:0];
            left_forward  = !left_mix[MIX_W-1];
            right_duty    = right_abs[DUTY_W-1:0];
            right_forward = !right_mix[MIX_W-1];
        end
    end

    assign o_stat.out_free = !r_valid || o_result.ready;
    assign o_target        = r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_wr) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= in_deadband ? '0 : i_target;
            r_base   <= i_base;
            r_turn   <= i_turn;
        end
        if (i_cmd.out_wr) begin
            r_left_duty     <= left_duty;
            r_left_forward  <= left_forward;
            r_right_duty    <= right_duty;
            r_right_forward <= right_forward;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.left_duty     = r_left_duty;
    assign o_result.left_forward  = r_left_forward;
    assign o_result.right_duty    = r_right_duty;
    assign o_result.right_forward = r_right_forward;

endmodule

/* hdl/dmsp_chk.sv */
// Port-level checker for dual_motor_speed_pi_loop, attached by bind.
// Depends on dmsp_pkg for the result field widths.
module dmsp_chk
    import dmsp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DUTY_W-1:0] i_left_duty,
    input logic              i_left_forward,
    input logic [DUTY_W-1:0] i_right_duty,
    input logic              i_right_forward
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("item accepted while previous tick still in work");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##10 i_out_valid)
        else $error("no result ten cycles after an accepted item");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a tick in work");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_left_duty)
            && $stable(i_left_forward) && $stable(i_right_duty)
            && $stable(i_right_forward))
        else $error("stalled result item changed");

endmodule

bind dual_motor_speed_pi_loop dmsp_chk u_dmsp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_left_duty     (o_result.left_duty),
    .i_left_forward  (o_result.left_forward),
    .i_right_duty    (o_result.right_duty),
    .i_right_forward (o_result.right_forward)
);

/* verif/tb_dmsp_pkg.sv */
`timescale 1ns / 100ps
// Tick and duty types and the duty scoreboard for the dual motor speed PI loop bench.
// Depends on dmsp_pkg for field widths, register indexes and reset values.
package tb_dmsp_pkg;
    import dmsp_pkg::*;

    localparam int     CNT_W     = 32;
    localparam int     FRAC_BITS = 10;
    localparam longint FRAC_ONE  = longint'(1) << FRAC_BITS;
    localparam longint Q16_ONE   = 65536;
    localparam longint S32_MAX   = 64'sh7FFF_FFFF;
    localparam longint S32_MIN   = -S32_MAX - 1;
    localparam int     SHOW_MAX  = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [CNT_W-1:0]    count_a;
        logic [CNT_W-1:0]    count_b;
        logic [TARGET_W-1:0] target;
        logic [BASE_W-1:0]   base;
        logic                turn;
    } t_tick;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic              left_fwd;
        logic [DUTY_W-1:0] right_duty;
        logic              right_fwd;
    } t_duty;

    class duty_scoreboard;
        logic [GAIN_W-1:0]   gd_a, ge_a, gd_b, ge_b;
        logic [WEIGHT_W-1:0] weight;
        logic [SCALE_W-1:0]  scale;
        logic [LIMIT_W-1:0]  limit;
        logic [CNT_W-1:0]    last_a, last_b;
        int                  filt_a, filt_b, perr_a, perr_b;
        longint              acc_a, acc_b;
        t_duty               expected_duty[$];
        int                  mismatches;

        function new();
            gd_a       = RST_GAIN_DIFF_A;
            ge_a       = RST_GAIN_ERR_A;
            gd_b       = RST_GAIN_DIFF_B;
            ge_b       = RST_GAIN_ERR_B;
            weight     = RST_SMOOTHING;
            scale      = RST_COUNT_TO_SPEED;
            limit      = RST_DRIVE_LIMIT;
            last_a     = '0;
            last_b     = '0;
            filt_a     = 0;
            filt_b     = 0;
            perr_a     = 0;
            perr_b     = 0;
            acc_a      = 0;
            acc_b      = 0;
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= SHOW_MAX)
                $display("ERROR at %0t: %s", $time, msg);
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_DIFF_A:    gd_a   = data[GAIN_W-1:0];
                REG_GAIN_ERR_A:     ge_a   = data[GAIN_W-1:0];
                REG_GAIN_DIFF_B:    gd_b   = data[GAIN_W-1:0];
                REG_GAIN_ERR_B:     ge_b   = data[GAIN_W-1:0];
                REG_SMOOTHING:      weight = data[WEIGHT_W-1:0];
                REG_COUNT_TO_SPEED: scale  = data[SCALE_W-1:0];
                REG_DRIVE_LIMIT:    limit  = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint smooth(logic [CNT_W-1:0] delta, int filt);
            longint raw, w;
            raw = longint'($signed(delta)) * longint'(scale);
            if (raw > S32_MAX)
                raw = S32_MAX;
            if (raw < S32_MIN)
                raw = S32_MIN;
            w = (weight > WEIGHT_ONE) ? Q16_ONE : longint'(weight);
            return (w * raw + (Q16_ONE - w) * longint'(filt)) >>> Q16_SHIFT;
        endfunction

        function longint pi_update(longint tgt, longint spd, longint gd, longint ge,
                                   longint acc, int perr, output int err);
            longint e, lim, a;
            e   = tgt - spd;
            lim = longint'(limit) * FRAC_ONE;
            a   = acc + gd * (e - longint'(perr)) + ge * e;
            if (a > lim)
                a = lim;
            if (a < -lim)
                a = -lim;
            err = int'(e);
            return a;
        endfunction

        function void take_tick(t_tick t);
            longint fa, fb, spd_a, spd_b, tgt, base, pa, pb, l, r;
            t_duty  d;
            fa     = smooth(t.count_a - last_a, filt_a);
            last_a = t.count_a;
            filt_a = int'(fa);
            spd_a  = fa / Q16_ONE;
            fb     = smooth(t.count_b - last_b, filt_b);
            last_b = t.count_b;
            filt_b = int'(fb);
            spd_b  = fb / Q16_ONE;

            tgt  = longint'($signed(t.target));
            base = longint'($signed(t.base));
            if (!t.turn && tgt > -longint'(DEADBAND) && tgt < longint'(DEADBAND))
                tgt = 0;
            acc_a = pi_update(tgt, spd_a, longint'(gd_a), longint'(ge_a), acc_a, perr_a, perr_a);
            acc_b = pi_update(tgt, spd_b, longint'(gd_b), longint'(ge_b), acc_b, perr_b, perr_b);
            pa = acc_a / FRAC_ONE;
            pb = acc_b / FRAC_ONE;

            if (t.turn) begin
                r = base + ((pb < 0) ? -pb : pb);
                if (r < 0)
                    r = 0;
                d.left_duty  = '0;
                d.left_fwd   = (pa > 0);
                d.right_duty = DUTY_W'(r);
                d.right_fwd  = (pb > 0);
            end else begin
                l = base - pa;
                r = base + pb;
                d.left_duty  = DUTY_W'((l < 0) ? -l : l);
                d.left_fwd   = (l >= 0);
                d.right_duty = DUTY_W'((r < 0) ? -r : r);
                d.right_fwd  = (r >= 0);
            end
            expected_duty.push_back(d);
        endfunction

        task check_duty(t_duty got);
            t_duty want;
            if (expected_duty.size() == 0) begin
                report_mismatch("result item with no tick waiting");
            end else begin
                want = expected_duty.pop_front();
                if (got.left_duty !== want.left_duty)
                    report_mismatch($sformatf("left_duty %0d, expected %0d",
                                              got.left_duty, want.left_duty));
                if (got.left_fwd !== want.left_fwd)
                    report_mismatch($sformatf("left_forward %0b, expected %0b",
                                              got.left_fwd, want.left_fwd));
                if (got.right_duty !== want.right_duty)
                    report_mismatch($sformatf("right_duty %0d, expected %0d",
                                              got.right_duty, want.right_duty));
                if (got.right_fwd !== want.right_fwd)
                    report_mismatch($sformatf("right_forward %0b, expected %0b",
                                              got.right_fwd, want.right_fwd));
            end
        endtask
    endclass

endpackage

/* verif/tb_dual_motor_speed_pi_loop.sv */
`timescale 1ns / 100ps
// Top of the dual motor speed PI loop bench: clock, reset, tick driver, duty receiver.
// Depends on dmsp_pkg, dmsp_if, tb_dmsp_pkg and the dual_motor_speed_pi_loop RTL.
module tb_dual_motor_speed_pi_loop;
    import dmsp_pkg::*;
    import tb_dmsp_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int STALL_LIMIT     = 1000;
    localparam int PHASES          = 6;
    localparam int TICKS_PER_PHASE = 146;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dmsp_item_if #(.COUNT_WIDTH(CNT_W)) item_ch ();
    dmsp_result_if                      result_ch ();

    duty_scoreboard   sb;
    int               src_idle;
    int               snk_idle;
    logic [CNT_W-1:0] run_a;
    logic [CNT_W-1:0] run_b;
    int               drift;

    dual_motor_speed_pi_loop #(
        .COUNT_WIDTH    (CNT_W),
        .GAIN_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic t_tick mk(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b,
                                 int tgt, int base, logic turn);
        t_tick t;
        t.count_a = a;
        t.count_b = b;
        t.target  = TARGET_W'(tgt);
        t.base    = BASE_W'(base);
        t.turn    = turn;
        return t;
    endfunction

    task automatic send_tick(t_tick t);
        if ($urandom_range(99) < src_idle) begin
            item_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        item_ch.valid        <= 1'b1;
        item_ch.enc_count_a  <= t.count_a;
        item_ch.enc_count_b  <= t.count_b;
        item_ch.target_speed <= t.target;
        item_ch.base_duty    <= t.base;
        item_ch.turn_mode    <= t.turn;
        do @(posedge i_clk); while (!item_ch.ready);
        sb.take_tick(t);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        while (sb.expected_duty.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_up_phase(int ph);
        case (ph)
            1: begin
                cfg_write(REG_GAIN_DIFF_A, $urandom_range(12000, 1000));
                cfg_write(REG_GAIN_ERR_A, $urandom_range(800));
                cfg_write(REG_GAIN_DIFF_B, $urandom_range(12000, 1000));
                cfg_write(REG_GAIN_ERR_B, $urandom_range(800));
                cfg_write(REG_SMOOTHING, 24'h01_0000);
                cfg_write(REG_COUNT_TO_SPEED, 24'h01_0000);
                cfg_write(REG_DRIVE_LIMIT, 24'd4095);
            end
            2: begin
                cfg_write(REG_GAIN_DIFF_A, 24'hFFFF);
                cfg_write(REG_GAIN_ERR_A, 24'hFFFF);
                cfg_write(REG_GAIN_DIFF_B, 24'hFFFF);
                cfg_write(REG_GAIN_ERR_B, 24'hFFFF);
                cfg_write(REG_SMOOTHING, 24'd0);
                cfg_write(REG_COUNT_TO_SPEED, 24'hFF_FFFF);
                cfg_write(REG_DRIVE_LIMIT, 24'd4095);
            end
            3: begin
                cfg_write(REG_GAIN_DIFF_A, 24'd0);
                cfg_write(REG_GAIN_ERR_A, $urandom_range(3000));
                cfg_write(REG_GAIN_DIFF_B, 24'd0);
                cfg_write(REG_GAIN_ERR_B, $urandom_range(3000));
                cfg_write(REG_SMOOTHING, 24'h01_FFFF);
                cfg_write(REG_COUNT_TO_SPEED, 24'd0);
                cfg_write(REG_DRIVE_LIMIT, 24'd0);
                cfg_write(REG_UNUSED, $urandom);
            end
            4: begin
                cfg_write(REG_GAIN_DIFF_A, $urandom);
                cfg_write(REG_GAIN_ERR_A, $urandom);
                cfg_write(REG_GAIN_DIFF_B, $urandom);
                cfg_write(REG_GAIN_ERR_B, $urandom);
                cfg_write(REG_SMOOTHING, $urandom);
                cfg_write(REG_COUNT_TO_SPEED, $urandom);
                cfg_write(REG_DRIVE_LIMIT, $urandom);
            end
            default: begin
                cfg_write(REG_GAIN_DIFF_A, $urandom_range(9000, 2000));
                cfg_write(REG_GAIN_ERR_A, $urandom_range(600, 1));
                cfg_write(REG_GAIN_DIFF_B, $urandom_range(9000, 2000));
                cfg_write(REG_GAIN_ERR_B, $urandom_range(600, 1));
                cfg_write(REG_SMOOTHING, $urandom_range(65536, 20000));
                cfg_write(REG_COUNT_TO_SPEED, RST_COUNT_TO_SPEED);
                cfg_write(REG_DRIVE_LIMIT, RST_DRIVE_LIMIT);
                cfg_write(REG_UNUSED, $urandom);
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    task automatic roll_tick(output t_tick t);
        int step_a;
        int step_b;
        int pick;
        if ($urandom_range(99) < 15) begin
            t.count_a = $urandom;
            t.count_b = $urandom;
            t.target  = TARGET_W'($urandom);
            t.base    = BASE_W'($urandom);
            t.turn    = $urandom_range(1);
        end else begin
            step_a = drift + $urandom_range(80) - 40;
            step_b = -drift + $urandom_range(80) - 40;
            if ($urandom_range(19) == 0)
                step_a = $urandom_range(131070) - 65535;
            if ($urandom_range(19) == 0)
                step_b = $urandom_range(131070) - 65535;
            run_a     = run_a + step_a;
            run_b     = run_b + step_b;
            t.count_a = run_a;
            t.count_b = run_b;
            pick      = $urandom_range(99);
            if (pick < 10)
                t.target = TARGET_W'($urandom_range(12) - 6);
            else if (pick < 25)
                t.target = TARGET_W'($urandom);
            else
                t.target = TARGET_W'($urandom_range(700) - 350);
            if ($urandom_range(99) < 25)
                t.base = BASE_W'($urandom);
            else
                t.base = BASE_W'($urandom_range(1200) - 600);
            t.turn = ($urandom_range(99) < 30);
        end
    endtask

    initial begin
        t_tick t;
        sb = new();
        src_idle             = 34;
        snk_idle             = 51;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= '0;
        i_cfg_data           <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.enc_count_a  <= '0;
        item_ch.enc_count_b  <= '0;
        item_ch.target_speed <= '0;
        item_ch.base_duty    <= '0;
        item_ch.turn_mode    <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tick(mk(0, 0, 0, 0, 1'b0));
        send_tick(mk(100, -100, 100, 500, 1'b0));
        send_tick(mk(200, -200, 4, 0, 1'b0));
        send_tick(mk(300, -300, -4, 0, 1'b0));
        send_tick(mk(400, -400, 5, -300, 1'b0));
        send_tick(mk(500, -500, -5, 300, 1'b0));
        send_tick(mk(600, -600, 3, 100, 1'b1));
        send_tick(mk(650, -650, -50, -4096, 1'b1));
        send_tick(mk(700, -700, 32767, 4095, 1'b1));
        send_tick(mk(800, -800, 32767, 4095, 1'b0));
        send_tick(mk(900, -900, -32768, -4096, 1'b0));
        send_tick(mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1'b0));
        send_tick(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1'b0));
        send_tick(mk(32'hFFFF_FFFF, 0, 0, 0, 1'b1));
        send_tick(mk(0, 32'hFFFF_FFFF, 0, 0, 1'b0));
        repeat (3) send_tick(mk(0, 0, 32767, 0, 1'b0));
        repeat (3) send_tick(mk(0, 0, -32768, 0, 1'b1));
        send_tick(mk(0, 0, 0, -1, 1'b1));

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                set_up_phase(ph);
            end
            src_idle = (ph < 2) ? 34 : (ph < 4) ? 51 : 0;
            snk_idle = (ph < 2) ? 51 : (ph < 4) ? 34 : 0;
            run_a    = 32'h7FFF_C000;
            run_b    = 32'h0000_4000;
            drift    = $urandom_range(300, 50);
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                roll_tick(t);
                send_tick(t);
            end
        end
        item_ch.valid <= 1'b0;

        while (sb.expected_duty.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.expected_duty.size() != 0)
            sb.report_mismatch("expected result items never arrived");
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        t_duty got;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                got.left_duty  = result_ch.left_duty;
                got.left_fwd   = result_ch.left_forward;
                got.right_duty = result_ch.right_duty;
                got.right_fwd  = result_ch.right_forward;
                sb.check_duty(got);
            end
            result_ch.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
